// ===== rtl/core/lse_pkg.sv =====
// Shared types and constants for the LSB payload extractor.
// No dependencies; imported by every module of the block.
package lse_pkg;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Largest magic accepted
  localparam int MAX_MAGIC_CHARS = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER_SKIP  = 2'd0;
  localparam logic [1:0] REG_MAGIC_TEXT   = 2'd1;
  localparam logic [1:0] REG_MAGIC_LENGTH = 2'd2;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_EXT      = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  // One token from the front: a restart mark and/or one hidden bit
  typedef struct packed {
    logic restart;
    logic has_lsb;
    logic lsb;
  } token_t;

  // One result item
  typedef struct packed {
    logic [7:0] result_byte;
    kind_t      kind;
    logic       last;
  } result_t;

  // A length word with its top bit set counts as zero
  function automatic logic [30:0] size_of_word(input logic [31:0] w);
    logic [30:0] s;
    s = w[31] ? 31'd0 : w[30:0];
    return s;
  endfunction

endpackage

// ===== rtl/core/lse_front.sv =====
// Front of the extractor: accepts image bytes, skips the header and
// turns each carrier byte into a hidden-bit token. Depends on lse_pkg.
module lse_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      header_skip,
  input  logic            in_valid,
  input  logic [7:0]      image_byte,
  input  logic            first_of_image,
  input  logic            queue_full,
  output logic            in_ready,
  output logic            push,
  output lse_pkg::token_t push_token
);
  import lse_pkg::*;

  logic       in_header;
  logic       in_header_next;
  logic [7:0] header_count;
  logic [7:0] header_count_next;
  logic       hdr_w;
  logic [7:0] cnt_w;
  logic       skip_byte;
  logic       accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Classify the byte: header or carrier, with restart applied first
  always_comb begin
    hdr_w = first_of_image ? 1'b1 : in_header;
    cnt_w = first_of_image ? 8'd0 : header_count;
    skip_byte = hdr_w && (cnt_w < header_skip);
    header_count_next = skip_byte ? cnt_w + 8'd1 : cnt_w;
    in_header_next = skip_byte;
    push_token.restart = first_of_image;
    push_token.has_lsb = !skip_byte;
    push_token.lsb     = image_byte[0];
    push = accept && (first_of_image || !skip_byte);
  end

  // Hold the header position
  always_ff @(posedge clk) begin
    if (rst) begin
      in_header    <= 1'b1;
      header_count <= 8'd0;
    end else if (accept) begin
      in_header    <= in_header_next;
      header_count <= header_count_next;
    end
  end

endmodule

// ===== rtl/core/lse_queue.sv =====
// Short token queue between the front and the back of the extractor.
// Depends on lse_pkg for the depth and the token type.
module lse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lse_pkg::token_t push_token,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output lse_pkg::token_t head
);
  import lse_pkg::*;

  token_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  // Store incoming tokens
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |-> !full)
    else $error("token pushed into a full queue");

endmodule

// ===== rtl/core/lse_back.sv =====
// Back of the extractor: assembles hidden bits into words and bytes, walks
// the payload layout and drives the result register. Depends on lse_pkg.
module lse_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [63:0]      magic_text,
  input  logic [3:0]       magic_length,
  input  logic             tok_valid,
  input  lse_pkg::token_t  tok,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output lse_pkg::result_t out_res
);
  import lse_pkg::*;

  typedef enum logic [6:0] {
    PH_MLEN  = 7'b0000001,
    PH_MAGIC = 7'b0000010,
    PH_ESIZE = 7'b0000100,
    PH_EXT   = 7'b0001000,
    PH_DSIZE = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_STOP  = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next, ph_w;
  logic [4:0]  bit_count, bit_count_next, cnt_w;
  logic [31:0] bit_shifter, bit_shifter_next, sh_w, word;
  logic [30:0] remaining, remaining_next, rem_w, rem_dec, wsize;
  logic [3:0]  magic_index, magic_index_next, idx_w;
  logic        mismatch, mismatch_next, mis_w;
  logic [3:0]  eff_len;
  logic [7:0]  expected;
  logic        need32, full_word, emit;
  result_t     res;

  assign pop     = tok_valid && (!out_valid || out_ready);
  assign eff_len = (magic_length > 4'(MAX_MAGIC_CHARS)) ? 4'(MAX_MAGIC_CHARS) : magic_length;

  // Decode one token against the current phase
  always_comb begin
    ph_w  = tok.restart ? PH_MLEN : phase;
    cnt_w = tok.restart ? 5'd0  : bit_count;
    sh_w  = tok.restart ? 32'd0 : bit_shifter;
    rem_w = tok.restart ? 31'd0 : remaining;
    idx_w = tok.restart ? 4'd0  : magic_index;
    mis_w = tok.restart ? 1'b0  : mismatch;

    phase_next       = ph_w;
    bit_count_next   = cnt_w;
    bit_shifter_next = sh_w;
    remaining_next   = rem_w;
    magic_index_next = idx_w;
    mismatch_next    = mis_w;
    emit             = 1'b0;
    res.result_byte  = 8'd0;
    res.kind         = KIND_EXT;
    res.last         = 1'b0;

    word      = {sh_w[30:0], tok.lsb};
    wsize     = size_of_word(word);
    rem_dec   = (rem_w != '0) ? rem_w - 31'd1 : rem_w;
    expected  = magic_text[{idx_w[2:0], 3'b000} +: 8];
    need32    = (ph_w == PH_MLEN) || (ph_w == PH_ESIZE) || (ph_w == PH_DSIZE);
    full_word = need32 ? (cnt_w == 5'd31) : (cnt_w == 5'd7);

    if (tok.has_lsb && (ph_w != PH_STOP)) begin
      if (!full_word) begin
        bit_count_next   = cnt_w + 5'd1;
        bit_shifter_next = word;
      end else begin
        bit_count_next   = 5'd0;
        bit_shifter_next = 32'd0;
        case (ph_w)
          PH_MLEN: begin
            if (wsize != {27'd0, eff_len}) begin
              phase_next = PH_STOP;
              emit       = 1'b1;
              res.kind   = KIND_MISMATCH;
              res.last   = 1'b1;
            end else begin
              remaining_next   = {27'd0, eff_len};
              magic_index_next = 4'd0;
              mismatch_next    = 1'b0;
              phase_next       = (eff_len != 4'd0) ? PH_MAGIC : PH_ESIZE;
            end
          end
          PH_MAGIC: begin
            mismatch_next    = mis_w || (word[7:0] != expected);
            magic_index_next = idx_w + 4'd1;
            remaining_next   = rem_dec;
            if (rem_dec == '0) begin
              if (mismatch_next) begin
                phase_next = PH_STOP;
                emit       = 1'b1;
                res.kind   = KIND_MISMATCH;
                res.last   = 1'b1;
              end else begin
                phase_next = PH_ESIZE;
              end
            end
          end
          PH_ESIZE: begin
            remaining_next = wsize;
            phase_next     = (wsize != '0) ? PH_EXT : PH_DSIZE;
          end
          PH_EXT: begin
            remaining_next  = rem_dec;
            phase_next      = (rem_dec == '0) ? PH_DSIZE : PH_EXT;
            emit            = 1'b1;
            res.result_byte = word[7:0];
            res.kind        = KIND_EXT;
          end
          PH_DSIZE: begin
            remaining_next = wsize;
            if (wsize == '0) begin
              phase_next = PH_STOP;
              emit       = 1'b1;
              res.kind   = KIND_EMPTY;
              res.last   = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            remaining_next  = rem_dec;
            emit            = 1'b1;
            res.result_byte = word[7:0];
            res.kind        = KIND_DATA;
            res.last        = (rem_dec == '0);
            phase_next      = (rem_dec == '0) ? PH_STOP : PH_DATA;
          end
          default: begin
            phase_next = PH_STOP;
          end
        endcase
      end
    end
  end

  // Advance the parse state on each popped token
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MLEN;
      bit_count   <= 5'd0;
      bit_shifter <= 32'd0;
      remaining   <= 31'd0;
      magic_index <= 4'd0;
      mismatch    <= 1'b0;
    end else if (pop) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      bit_shifter <= bit_shifter_next;
      remaining   <= remaining_next;
      magic_index <= magic_index_next;
      mismatch    <= mismatch_next;
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_res <= res;
    end
  end

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("phase register not one-hot");

  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (pop && emit && res.last) |=> (phase == PH_STOP))
    else $error("final result did not stop the parse");

  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_MAGIC) || (phase == PH_EXT) || (phase == PH_DATA)) |-> (bit_count < 5'd8))
    else $error("bit count overran a byte phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop)
    else $error("token popped while result stalled");

endmodule

// ===== rtl/core/lsb_stego_payload_extractor.sv =====
// Top level of the LSB payload extractor: configuration registers, front,
// token queue and back. Depends on lse_pkg, lse_front, lse_queue, lse_back.
//
// The block takes one carrier byte per cycle on the s_ stream, with tuser
// marking the first byte of an image, and returns recovered extension and
// data bytes, or a status, on the m_ stream. It sustains one image byte per
// clock while the queue has room: the front skips header bytes and passes one
// hidden bit per carrier byte into a four-entry queue, and the back folds one
// bit per cycle, unless the result register is stalled, into its word shifter
// and walks the magic, extension and data fields. The token queue and the
// result register lie between the input transaction that completes a result
// and m_tvalid; a stalled output holds its result while the queue keeps
// absorbing input until it is full. Configuration writes take effect on the next
// cycle and must be made while no image is in flight; the block does not enforce it.
module lsb_stego_payload_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // image_byte[7:0]
  input  logic [0:0]  s_tuser,   // first_of_image[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // result_byte[7:0]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import lse_pkg::*;

  logic [7:0]  header_skip;
  logic [63:0] magic_text;
  logic [3:0]  magic_length;
  logic        push, pop, queue_full, queue_not_empty;
  token_t      push_token, head;
  result_t     out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_skip  <= 8'd54;
      magic_text   <= 64'd0;
      magic_length <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_SKIP:  header_skip  <= cfg_data[7:0];
        REG_MAGIC_TEXT:   magic_text   <= cfg_data;
        REG_MAGIC_LENGTH: magic_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lse_front u_front (
    .clk            (clk),
    .rst            (rst),
    .header_skip    (header_skip),
    .in_valid       (s_tvalid),
    .image_byte     (s_tdata),
    .first_of_image (s_tuser[0]),
    .queue_full     (queue_full),
    .in_ready       (s_tready),
    .push           (push),
    .push_token     (push_token)
  );

  lse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  lse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .magic_text   (magic_text),
    .magic_length (magic_length),
    .tok_valid    (queue_not_empty),
    .tok          (head),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_res      (out_res)
  );

  assign m_tdata = out_res.result_byte;
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for lsb_stego_payload_extractor: builds carrier images
// with hidden payloads, decodes them alongside the block and compares every result.
// Depends on lse_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module testbench;
  import lse_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam int TOTAL_ITEMS  = 1950;
  localparam int MAX_PRINTS   = 50;

  // Register index that decodes to nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Idle percentages of each traffic phase
  localparam int IDLE_BUSY = 84;
  localparam int IDLE_BOTH = 21;

  typedef enum logic [2:0] {
    PH_HEADER, PH_MLEN, PH_MAGIC, PH_ESIZE, PH_EXT, PH_DSIZE, PH_DATA, PH_STOP
  } parse_phase_t;

  // Mirror of the decode: notes each accepted carrier byte, holds the results due
  class hidden_payload_decoder;
    logic [7:0]   skip_reg;
    logic [63:0]  magic_reg;
    logic [3:0]   mlen_reg;
    parse_phase_t phase;
    logic [7:0]   hdr_count;
    logic [4:0]   bit_count;
    logic [31:0]  shifter;
    logic [30:0]  remaining;
    logic [3:0]   magic_idx;
    logic         mismatch;
    result_t      results_due[$];
    int           errors;
    int           results_seen;

    function new();
      skip_reg     = 8'd54;
      magic_reg    = '0;
      mlen_reg     = '0;
      errors       = 0;
      results_seen = 0;
      restart_parse();
    endfunction

    function void restart_parse();
      phase     = PH_HEADER;
      hdr_count = '0;
      bit_count = '0;
      shifter   = '0;
      remaining = '0;
      magic_idx = '0;
      mismatch  = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_HEADER_SKIP:  skip_reg  = val[7:0];
        REG_MAGIC_TEXT:   magic_reg = val;
        REG_MAGIC_LENGTH: mlen_reg  = val[3:0];
        default: ;
      endcase
    endfunction

    // A word with the top bit set counts as an empty size
    function logic [30:0] word_to_size(logic [31:0] w);
      return w[31] ? 31'd0 : w[30:0];
    endfunction

    function void push_result(logic [7:0] b, kind_t k, logic l);
      result_t r;
      r.result_byte = b;
      r.kind        = k;
      r.last        = l;
      results_due.push_back(r);
    endfunction

    function void note_carrier_byte(logic [7:0] b, logic first);
      logic [31:0] word;
      logic [3:0]  eff;
      logic [7:0]  want;
      int          need;
      if (first) restart_parse();
      // Skip the image header
      if (phase == PH_HEADER) begin
        if (hdr_count < skip_reg) begin
          hdr_count++;
          return;
        end
        phase = PH_MLEN;
      end
      if (phase == PH_STOP) return;
      // Gather hidden bits, MSB first
      shifter = {shifter[30:0], b[0]};
      need = (phase inside {PH_MLEN, PH_ESIZE, PH_DSIZE}) ? 32 : 8;
      if (int'(bit_count) + 1 < need) begin
        bit_count++;
        return;
      end
      bit_count = '0;
      word      = shifter;
      shifter   = '0;
      case (phase)
        PH_MLEN: begin
          eff = (mlen_reg > MAX_MAGIC_CHARS) ? 4'(MAX_MAGIC_CHARS) : mlen_reg;
          if (word_to_size(word) != 31'(eff)) begin
            phase = PH_STOP;
            push_result(8'd0, KIND_MISMATCH, 1'b1);
          end else begin
            remaining = 31'(eff);
            magic_idx = '0;
            mismatch  = 1'b0;
            phase     = (eff != 0) ? PH_MAGIC : PH_ESIZE;
          end
        end
        PH_MAGIC: begin
          want = magic_reg[8*magic_idx[2:0] +: 8];
          if (word[7:0] != want) mismatch = 1'b1;
          magic_idx++;
          if (remaining != 0) remaining--;
          if (remaining == 0) begin
            if (mismatch) begin
              phase = PH_STOP;
              push_result(8'd0, KIND_MISMATCH, 1'b1);
            end else begin
              phase = PH_ESIZE;
            end
          end
        end
        PH_ESIZE: begin
          remaining = word_to_size(word);
          phase = (remaining != 0) ? PH_EXT : PH_DSIZE;
        end
        PH_EXT: begin
          if (remaining != 0) remaining--;
          if (remaining == 0) phase = PH_DSIZE;
          push_result(word[7:0], KIND_EXT, 1'b0);
        end
        PH_DSIZE: begin
          remaining = word_to_size(word);
          if (remaining == 0) begin
            phase = PH_STOP;
            push_result(8'd0, KIND_EMPTY, 1'b1);
          end else begin
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          if (remaining != 0) remaining--;
          if (remaining == 0) begin
            phase = PH_STOP;
            push_result(word[7:0], KIND_DATA, 1'b1);
          end else begin
            push_result(word[7:0], KIND_DATA, 1'b0);
          end
        end
        default: phase = PH_STOP;
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch: %s", what);
    endtask

    task check_recovered(result_t got);
      result_t want;
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h kind %0d last %0d",
                                  got.result_byte, got.kind, got.last));
        return;
      end
      want = results_due.pop_front();
      if (got.result_byte !== want.result_byte || got.kind !== want.kind ||
          got.last !== want.last)
        report_mismatch($sformatf("result %0d: byte %02h/%02h kind %0d/%0d last %0d/%0d",
                                  results_seen, got.result_byte, want.result_byte,
                                  got.kind, want.kind, got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  hidden_payload_decoder decoder = new();

  int          cycle_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic [7:0]  cur_skip = 8'd54;
  logic [63:0] cur_text = '0;
  logic [3:0]  cur_len = '0;
  bit          hidden_bits[$];
  result_t     seen_result;

  lsb_stego_payload_extractor u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check each result transaction, then draw the next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      seen_result.result_byte = m_tdata;
      seen_result.kind        = kind_t'(m_tuser);
      seen_result.last        = m_tlast;
      decoder.check_recovered(seen_result);
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  function int magic_in_use();
    return (cur_len > MAX_MAGIC_CHARS) ? MAX_MAGIC_CHARS : int'(cur_len);
  endfunction

  // Favour the extreme byte values
  function logic [7:0] pick_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function void push_bits(logic [31:0] w, int n);
    for (int i = n - 1; i >= 0; i--) hidden_bits.push_back(w[i]);
  endfunction

  // Lay out the hidden payload; bad_char >= 0 corrupts that magic character
  function void build_payload(logic [31:0] len_word, int bad_char, logic [31:0] ext_word,
                              int ext_n, logic [31:0] data_word, int data_n);
    logic [7:0] c;
    hidden_bits.delete();
    push_bits(len_word, 32);
    for (int i = 0; i < magic_in_use(); i++) begin
      c = cur_text[8*i +: 8];
      if (i == bad_char) c = c ^ (8'd1 << $urandom_range(7));
      push_bits({24'd0, c}, 8);
    end
    push_bits(ext_word, 32);
    for (int i = 0; i < ext_n; i++) push_bits({24'd0, pick_byte()}, 8);
    push_bits(data_word, 32);
    for (int i = 0; i < data_n; i++) push_bits({24'd0, pick_byte()}, 8);
  endfunction

  // Offer one carrier byte and hold it until the transaction completes
  task send_byte(logic [7:0] b, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    decoder.note_carrier_byte(b, first);
  endtask

  // Header, then hidden bits up to cut_at, then trailing bytes without a restart
  task send_image(bit with_first, int cut_at, int trailing);
    logic [7:0] carrier;
    int         n;
    n = 0;
    for (int i = 0; i < int'(cur_skip); i++) begin
      send_byte(8'($urandom), with_first && n == 0);
      n++;
    end
    for (int i = 0; i < hidden_bits.size() && i < cut_at; i++) begin
      carrier    = 8'($urandom);
      carrier[0] = hidden_bits[i];
      send_byte(carrier, with_first && n == 0);
      n++;
    end
    items_sent += n;
    repeat (trailing) send_byte(8'($urandom), 1'b0);
    items_sent += trailing;
  endtask

  // Let every due result arrive and the pipeline empty
  task wait_drained();
    s_tvalid <= 1'b0;
    while (decoder.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_one(logic [1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    decoder.write_reg(idx, val);
  endtask

  // Write all registers, with junk above the skip and length fields and a write to no register
  task set_config(logic [7:0] skip, logic [63:0] text, logic [3:0] len);
    logic [63:0] junk;
    junk     = {$urandom, $urandom};
    cur_skip = skip;
    cur_text = text;
    cur_len  = len;
    write_one(REG_HEADER_SKIP, {junk[63:8], skip});
    write_one(REG_MAGIC_TEXT, text);
    write_one(REG_MAGIC_LENGTH, {junk[63:4], len});
    write_one(REG_UNUSED, ~junk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task random_image();
    int          r;
    int          eff;
    int          ext_n;
    int          data_n;
    int          bad;
    int          cut;
    logic [31:0] len_word;
    logic [31:0] ext_word;
    logic [31:0] data_word;
    r = $urandom_range(99);
    // Noise: random bytes with scattered restarts
    if (r >= 96) begin
      cut = $urandom_range(60, 20);
      repeat (cut) send_byte(8'($urandom), $urandom_range(19) == 0);
      items_sent += cut;
      return;
    end
    eff    = magic_in_use();
    ext_n  = $urandom_range(3);
    ext_word = ext_n;
    if ($urandom_range(9) == 0) begin
      ext_word = {1'b1, 31'($urandom)};
      ext_n    = 0;
    end
    data_n = $urandom_range(6);
    data_word = data_n;
    if ($urandom_range(9) == 0) begin
      data_word = {1'b1, 31'($urandom)};
      data_n    = 0;
    end
    len_word = eff;
    if (eff == 0 && $urandom_range(2) == 0) len_word = {1'b1, 31'($urandom)};
    bad = -1;
    // Broken magic: a wrong length word, or one wrong character
    if ((r >= 75 && r < 83) || (r >= 83 && r < 91 && eff == 0)) begin
      if (eff != 0 && $urandom_range(1) == 1) len_word = {1'b1, 31'($urandom)};
      else len_word = eff + 1 + $urandom_range(20);
    end else if (r >= 83 && r < 91) begin
      bad = $urandom_range(eff - 1);
    end
    build_payload(len_word, bad, ext_word, ext_n, data_word, data_n);
    cut = (r >= 91) ? $urandom_range(hidden_bits.size() - 1) : hidden_bits.size();
    send_image(1'b1, cut, $urandom_range(4));
  endtask

  initial begin
    int          group;
    int          r;
    logic [7:0]  skip;
    logic [63:0] text;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Decode straight after reset, no restart flag, default registers
    build_payload(32'd0, -1, 32'd0, 0, 32'd0, 0);
    send_image(1'b0, hidden_bits.size(), 3);
    wait_drained();

    set_config(8'd0, 64'h0000_0000_0063_6261, 4'd3);
    // Sender idles through the directed magic and size cases
    send_idle_pct = IDLE_BUSY;
    stall_pct     = 0;
    // Well-formed image
    build_payload(32'd3, -1, 32'd2, 2, 32'd3, 3);
    send_image(1'b1, hidden_bits.size(), 2);
    // Wrong magic length
    build_payload(32'd5, -1, 32'd1, 1, 32'd1, 1);
    send_image(1'b1, hidden_bits.size(), 2);
    // Wrong magic character
    build_payload(32'd3, 2, 32'd1, 1, 32'd1, 1);
    send_image(1'b1, hidden_bits.size(), 2);
    // Negative extension size
    build_payload(32'd3, -1, 32'hFFFF_FFFF, 0, 32'd1, 1);
    send_image(1'b1, hidden_bits.size(), 1);
    // Negative data size
    build_payload(32'd3, -1, 32'd1, 1, 32'h8000_0001, 0);
    send_image(1'b1, hidden_bits.size(), 1);
    // Huge extension abandoned by the next image
    build_payload(32'd3, -1, 32'h7FFF_FFFF, 5, 32'd0, 0);
    send_image(1'b1, hidden_bits.size(), 0);
    // Image cut inside the length word
    build_payload(32'd3, -1, 32'd1, 1, 32'd2, 2);
    send_image(1'b1, 17, 0);
    wait_drained();

    // Negative length word matches an empty magic, receiver stalling
    send_idle_pct = 0;
    stall_pct     = IDLE_BUSY;
    set_config(8'd0, 64'd0, 4'd0);
    build_payload({1'b1, 31'($urandom)}, -1, 32'd0, 0, 32'd2, 2);
    send_image(1'b1, hidden_bits.size(), 1);
    wait_drained();

    // Longest header, saturated magic length, both sides idling
    send_idle_pct = IDLE_BOTH;
    stall_pct     = IDLE_BOTH;
    set_config(8'd255, '1, 4'd15);
    build_payload(32'd8, -1, 32'd1, 1, 32'd1, 1);
    send_image(1'b1, hidden_bits.size(), 1);
    wait_drained();

    // Zero characters in the magic are ordinary
    send_idle_pct = 0;
    stall_pct     = 0;
    set_config(8'd0, 64'd0, 4'd8);
    build_payload(32'd8, -1, 32'd0, 0, 32'd4, 4);
    send_image(1'b1, hidden_bits.size(), 1);
    build_payload(32'd0, -1, 32'd0, 0, 32'd1, 1);
    send_image(1'b1, hidden_bits.size(), 1);

    // Random images, one traffic phase and register setting per group
    group = 0;
    while (items_sent < TOTAL_ITEMS) begin
      wait_drained();
      case (group % 4)
        0: begin send_idle_pct = 0;         stall_pct = 0;         end
        1: begin send_idle_pct = IDLE_BUSY; stall_pct = 0;         end
        2: begin send_idle_pct = 0;         stall_pct = IDLE_BUSY; end
        default: begin send_idle_pct = IDLE_BOTH; stall_pct = IDLE_BOTH; end
      endcase
      r = $urandom_range(9);
      skip = (r == 0) ? 8'd255 : (r == 1) ? 8'd0 : 8'($urandom_range(12, 1));
      r = $urandom_range(19);
      text = (r < 3) ? 64'd0 : (r < 6) ? '1 : {$urandom, $urandom};
      set_config(skip, text, 4'($urandom_range(15)));
      repeat (2) random_image();
      group++;
    end

    wait_drained();
    if (decoder.results_due.size() != 0)
      decoder.report_mismatch($sformatf("%0d results never arrived",
                                        decoder.results_due.size()));
    if (decoder.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
